FILE: design/rwct_pkg.sv
package rwct_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SETUP  = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_EMIT
  } bk_state_t;

  localparam int unsigned HEIGHT_MAX = 24'hFFFFFF;

  typedef struct packed {
    op_t          op;
    logic [11:0]  ray_x;
    logic [11:0]  ray_y;
    logic [19:0]  player_x;
    logic [19:0]  player_y;
    logic signed [15:0] dir_cos;
    logic signed [15:0] dir_sin;
    logic [9:0]   column;
    logic [8:0]   row;
    logic         texture_select;
    logic [11:0]  texel_index;
    logic [31:0]  texel_color;
  } beat_t;

endpackage

FILE: design/rwct_fifo.sv
module rwct_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rwct_pkg::beat_t push_data,
  input  logic           pop,
  output rwct_pkg::beat_t pop_data,
  output logic           empty,
  output logic           full
);
  import rwct_pkg::*;

  beat_t      slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign pop_data = slot_r[rp_r];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
endmodule

FILE: design/rwct_div.sv
module rwct_div #(
  parameter int NW = 48,
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem_r[DW-1:0], q_r[NW-1]};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        q_r <= num;
        d_r <= den;
        rem_r <= '0;
        cnt_r <= CW'(NW);
      end else if (busy_r) begin
        if (!diff[DW]) begin
          rem_r <= diff;
          q_r <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q_r;
endmodule

FILE: design/rwct_back.sv
module rwct_back #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int TILE_SIZE     = 64,
  parameter int TEX_SIZE      = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  rwct_pkg::beat_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  output logic [9:0]      out_column,
  output logic [8:0]      out_row,
  output logic [31:0]     color
);
  import rwct_pkg::*;

  localparam int TA  = TEX_SIZE * TEX_SIZE;
  localparam int TB  = $clog2(TEX_SIZE);
  localparam int AB  = $clog2(2 * TA);
  localparam int TLB = $clog2(TILE_SIZE);
  localparam longint unsigned NUMC = longint'(TILE_SIZE) * (SCREEN_WIDTH / 2);

  logic [31:0] mem [2 * TA];

  bk_state_t st_r, st_nxt;
  logic        is_setup_r;
  logic [8:0]  row_r;
  logic [9:0]  column_r;
  logic signed [16:0] start_r, end_r;
  logic [23:0] height_r;
  logic [5:0]  texcol_r;
  logic        ns_r;

  logic signed [21:0] dx, dy;
  logic signed [38:0] ray_dist;
  logic [63:0] div_num;
  logic [63:0] div_den;
  logic        div_go, div_done;
  logic [63:0] quo;
  logic [23:0] h_new;
  logic signed [25:0] diff;
  logic signed [16:0] st_new;
  logic signed [25:0] end_sum;
  logic [TLB-1:0] offx, offy, off;
  logic signed [17:0] rrel;
  logic [31:0] ty;
  logic        in_span;
  logic [AB-1:0] addr;
  logic [AB-1:0] raddr;
  logic        ty_ok;
  logic        dist_pos_r;

  assign dx = $signed({2'b0, q_data.ray_x, 8'b0}) - $signed({2'b0, q_data.player_x});
  assign dy = $signed({2'b0, q_data.ray_y, 8'b0}) - $signed({2'b0, q_data.player_y});
  assign ray_dist = 39'(dx * q_data.dir_cos) + 39'(dy * q_data.dir_sin);

  assign rrel = $signed({9'b0, q_data.row}) - 18'(start_r);
  assign in_span = ($signed({8'b0, q_data.row}) >= start_r) &&
                   ($signed({8'b0, q_data.row}) < end_r) &&
                   (int'(q_data.row) < SCREEN_HEIGHT) && (height_r != 24'd0);

  always_comb begin
    div_go = 1'b0;
    div_num = '0;
    div_den = 64'd1;
    if (st_r == BK_IDLE && !q_empty) begin
      if (q_data.op == OP_SETUP && ray_dist > 0) begin
        div_go = 1'b1;
        div_num = 64'(NUMC) << 30;
        div_den = 64'(ray_dist);
      end else if (q_data.op == OP_SAMPLE && in_span) begin
        div_go = 1'b1;
        div_num = 64'(rrel) * 64'(TEX_SIZE * 256);
        div_den = {40'b0, height_r};
      end
    end
  end

  rwct_div #(.NW(64), .DW(64)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(quo)
  );

  assign h_new = (!dist_pos_r || quo > 64'(HEIGHT_MAX)) ? 24'hFFFFFF : quo[23:0];
  assign diff = 26'(SCREEN_HEIGHT * 256) - $signed({2'b0, h_new});
  assign st_new = 17'(diff / 512);
  assign end_sum = 26'(st_new) * 26'sd256 + $signed({2'b0, h_new});
  assign offx = q_data.ray_x[TLB-1:0];
  assign offy = q_data.ray_y[TLB-1:0];
  assign off = (offx != '0) ? offx : offy;
  assign ty = quo[31:0];
  assign ty_ok = (quo < 64'(TEX_SIZE)) && (int'(texcol_r) < TEX_SIZE);
  assign addr = AB'((ns_r ? 0 : TA) + int'(ty[TB-1:0]) * TEX_SIZE + int'(texcol_r));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (!q_empty) begin
        if (q_data.op == OP_SETUP) st_nxt = (ray_dist > 0) ? BK_DIV : BK_READ;
        else if (q_data.op == OP_SAMPLE && in_span) st_nxt = BK_DIV;
      end
      BK_DIV:  if (div_done) st_nxt = BK_READ;
      BK_READ: st_nxt = is_setup_r ? BK_IDLE : BK_EMIT;
      BK_EMIT: st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    case (st_r)
      BK_IDLE: q_pop = !q_empty && (q_data.op != OP_SETUP) &&
                       !(q_data.op == OP_SAMPLE && in_span);
      BK_READ: q_pop = 1'b1;
      default: q_pop = 1'b0;
    endcase
  end

  assign raddr = addr;

  always_ff @(posedge clk) begin
    if (st_r == BK_IDLE && !q_empty && q_data.op == OP_LOAD &&
        int'(q_data.texel_index) < TA)
      mem[AB'(q_data.texture_select ? TA : 0) + AB'(q_data.texel_index)] <=
        q_data.texel_color;
    if (st_r == BK_IDLE) begin
      is_setup_r <= (q_data.op == OP_SETUP);
      dist_pos_r <= (ray_dist > 0);
      row_r <= q_data.row;
    end
    if (st_r == BK_READ) color <= ty_ok ? mem[raddr] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      column_r <= '0;
      start_r <= '0;
      end_r <= '0;
      height_r <= '0;
      texcol_r <= '0;
      ns_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_READ && is_setup_r) begin
        column_r <= q_data.column;
        height_r <= h_new;
        start_r <= st_new;
        end_r <= 17'(end_sum / 256);
        ns_r <= (offx != '0);
        texcol_r <= 6'((int'(off) * TEX_SIZE) / TILE_SIZE);
      end
    end
  end

  assign out_valid = (st_r == BK_EMIT);
  assign out_column = column_r;
  assign out_row = row_r;
endmodule

FILE: design/raycast_wall_column_texturer_unit.sv
// channel | ports                         | handshake
// in      | in_*                          | start && !busy
// out     | out_column, out_row, out_color| out_valid, one cycle
// Load, ignored and out-of-span sample items are popped in the back end's idle state.
// A set-up runs the divider, then a read state (no divide when the distance is not
// positive); an in-span sample runs the bit-serial divider, a read and an emit state.
// A two-beat queue parts the intake from the back end; busy is queue full.
// Reset clears control state; texture contents are undefined until written.
// The receiver cannot stall.
module raycast_wall_column_texturer_unit #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int TILE_SIZE     = 64,
  parameter int TEX_SIZE      = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [11:0] in_ray_x,
  input  logic [11:0] in_ray_y,
  input  logic [19:0] in_player_x,
  input  logic [19:0] in_player_y,
  input  logic signed [15:0] in_dir_cos,
  input  logic signed [15:0] in_dir_sin,
  input  logic [9:0]  in_column,
  input  logic [8:0]  in_row,
  input  logic        in_texture_select,
  input  logic [11:0] in_texel_index,
  input  logic [31:0] in_texel_color,
  output logic        out_valid,
  output logic [9:0]  out_column,
  output logic [8:0]  out_row,
  output logic [31:0] out_color
);
  import rwct_pkg::*;

  beat_t in_beat, q_data;
  logic  push, q_pop, q_empty, q_full;

  assign in_beat = '{op: op_t'(in_op), ray_x: in_ray_x, ray_y: in_ray_y,
                     player_x: in_player_x, player_y: in_player_y,
                     dir_cos: in_dir_cos, dir_sin: in_dir_sin, column: in_column,
                     row: in_row, texture_select: in_texture_select,
                     texel_index: in_texel_index, texel_color: in_texel_color};
  assign busy = q_full;
  assign push = start && !busy;

  rwct_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(in_beat), .pop(q_pop),
    .pop_data(q_data), .empty(q_empty), .full(q_full)
  );

  rwct_back #(
    .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .TILE_SIZE(TILE_SIZE), .TEX_SIZE(TEX_SIZE)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_column(out_column), .out_row(out_row),
    .color(out_color)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_row) < SCREEN_HEIGHT)) else $error("row out of range");
endmodule
